>>> design/tacc_pkg.sv
// tacc_pkg: shared types and constants of the tiny accumulator core
// transaction payload structs, datapath command/status structs, opcodes, status codes
// no dependencies
package tacc_pkg;

    // item operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_EXEC    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // configuration register indexes
    localparam logic CFG_PROG_LEN   = 1'b0;
    localparam logic CFG_STEP_LIMIT = 1'b1;

    // configuration reset values
    localparam logic [8:0]  PROG_LEN_RST   = 9'd256;
    localparam logic [15:0] STEP_LIMIT_RST = 16'd200;

    // status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_RUN     = 3'd0;
    localparam t_status ST_HLT     = 3'd1;
    localparam t_status ST_BADOP   = 3'd2;
    localparam t_status ST_PASTEND = 3'd3;
    localparam t_status ST_ATEND   = 3'd4;
    localparam t_status ST_LIMIT   = 3'd5;

    // instruction opcodes
    localparam logic [7:0] OPC_LDA = 8'h01;
    localparam logic [7:0] OPC_LDX = 8'h02;
    localparam logic [7:0] OPC_ADC = 8'h03;
    localparam logic [7:0] OPC_INX = 8'h04;
    localparam logic [7:0] OPC_DEX = 8'h05;
    localparam logic [7:0] OPC_JMP = 8'h06;
    localparam logic [7:0] OPC_JSR = 8'h07;
    localparam logic [7:0] OPC_RTS = 8'h08;
    localparam logic [7:0] OPC_BEQ = 8'h09;
    localparam logic [7:0] OPC_BNE = 8'h0A;
    localparam logic [7:0] OPC_NOP = 8'h0B;
    localparam logic [7:0] OPC_HLT = 8'h0C;

    localparam logic [7:0] SP_RST = 8'hFF;

    // input transaction
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] addr;
        logic [7:0] data;
    } t_in;

    // result transaction
    typedef struct packed {
        t_status     status;
        logic [15:0] prog_counter;
        logic [7:0]  opcode;
        logic [7:0]  acc;
        logic [7:0]  index_reg;
        logic        zero_flag;
        logic        carry_flag;
        logic [7:0]  stack_ptr;
        logic [15:0] step_count;
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic clr_opc;
        logic prog_write;
        logic restart;
        logic fetch;
        logic take_opc;
        logic step_inc;
        logic imm_exec;
        logic inc_x;
        logic dec_x;
        logic set_hlt;
        logic set_badop;
        logic take_lo;
        logic load_tgt;
        logic push_hi;
        logic push_lo_jump;
        logic pop_start;
        logic pop_lo;
        logic pop_done;
        logic report;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [7:0] fetch_byte;
        logic [7:0] opc;
        logic       zf;
        logic       run;
    } t_stat;

endpackage

>>> design/tiny_accumulator_cpu_core.sv
// tiny_accumulator_cpu_core: top level of the 8-bit accumulator processor
// joins tacc_ctrl and tacc_dpath; uses tacc_pkg
//
// An item is taken when start is high and busy is low; each item gives one result,
// shown on o_res for a single cycle with o_res_valid high, and the receiver cannot
// stall it. Busy falls in the cycle the result is shown, so the next item may be
// taken then. Loads, restarts and refused steps go straight to the report. An
// executed instruction reads its bytes in turn from the single-port program store:
// opcode, an immediate for LDA/LDX/ADC or a two-byte target for JMP/BEQ/BNE/JSR;
// JSR pushes, RTS pops a return pc. Configuration writes are always ready and are
// meant to arrive only while no item is in flight.
module tiny_accumulator_cpu_core
    import tacc_pkg::*;
#(
    parameter int PROG_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_in,
    output t_res        o_res,
    output logic        o_res_valid,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    tacc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_in.op),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // registers and stores
    tacc_dpath #(
        .PROG_DEPTH (PROG_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

endmodule

>>> design/tacc_ctrl.sv
// tacc_ctrl: instruction sequencer of the tiny accumulator core
// one-hot state machine issuing t_cmd to the datapath; uses tacc_pkg
module tacc_ctrl
    import tacc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_op,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_OPC    = 9'b000000010,
        S_IMM    = 9'b000000100,
        S_ALO    = 9'b000001000,
        S_AHI    = 9'b000010000,
        S_PUSH   = 9'b000100000,
        S_RLO    = 9'b001000000,
        S_RHI    = 9'b010000000,
        S_REPORT = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   w_take_branch;

    assign o_busy = (r_state != S_IDLE);

    // jump, or conditional branch taken on the zero flag
    assign w_take_branch = (i_stat.opc == OPC_JMP)
                        || ((i_stat.opc == OPC_BEQ) && i_stat.zf)
                        || ((i_stat.opc == OPC_BNE) && !i_stat.zf);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.clr_opc = 1'b1;
                    n_state       = S_REPORT;
                    if (i_op == OP_LOAD) begin
                        o_cmd.prog_write = 1'b1;
                    end else if (i_op == OP_RESTART) begin
                        o_cmd.restart = 1'b1;
                    end else if ((i_op == OP_EXEC) && i_stat.run) begin
                        o_cmd.fetch = 1'b1;
                        n_state     = S_OPC;
                    end
                end
            end
            S_OPC: begin
                o_cmd.take_opc = 1'b1;
                o_cmd.step_inc = 1'b1;
                n_state        = S_REPORT;
                unique case (i_stat.fetch_byte)
                    OPC_LDA, OPC_LDX, OPC_ADC: begin
                        o_cmd.fetch = 1'b1;
                        n_state     = S_IMM;
                    end
                    OPC_INX: o_cmd.inc_x = 1'b1;
                    OPC_DEX: o_cmd.dec_x = 1'b1;
                    OPC_JMP, OPC_JSR, OPC_BEQ, OPC_BNE: begin
                        o_cmd.fetch = 1'b1;
                        n_state     = S_ALO;
                    end
                    OPC_RTS: begin
                        o_cmd.pop_start = 1'b1;
                        n_state         = S_RLO;
                    end
                    OPC_NOP: ;
                    OPC_HLT: o_cmd.set_hlt = 1'b1;
                    default: o_cmd.set_badop = 1'b1;
                endcase
            end
            S_IMM: begin
                o_cmd.imm_exec = 1'b1;
                n_state        = S_REPORT;
            end
            S_ALO: begin
                o_cmd.take_lo = 1'b1;
                o_cmd.fetch   = 1'b1;
                n_state       = S_AHI;
            end
            S_AHI: begin
                if (i_stat.opc == OPC_JSR) begin
                    o_cmd.push_hi = 1'b1;
                    n_state       = S_PUSH;
                end else begin
                    o_cmd.load_tgt = w_take_branch;
                    n_state        = S_REPORT;
                end
            end
            S_PUSH: begin
                o_cmd.push_lo_jump = 1'b1;
                n_state            = S_REPORT;
            end
            S_RLO: begin
                o_cmd.pop_lo = 1'b1;
                n_state      = S_RHI;
            end
            S_RHI: begin
                o_cmd.pop_done = 1'b1;
                n_state        = S_REPORT;
            end
            S_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> design/tacc_dpath.sv
// tacc_dpath: registers, program store, stack store and result register of the core
// executes t_cmd from tacc_ctrl and returns t_stat; uses tacc_pkg
module tacc_dpath
    import tacc_pkg::*;
#(
    parameter int PROG_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in         i_in,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output t_res        o_res,
    output logic        o_res_valid
);

    localparam int AW = $clog2(PROG_DEPTH);

    // architectural state
    logic [7:0]  r_acc, r_x, r_sp;
    logic [15:0] r_pc, r_steps;
    logic        r_zf, r_cf;
    t_status     r_halt;
    logic [8:0]  r_prog_len;
    logic [15:0] r_limit;
    logic        r_res_valid;

    // per-instruction working registers
    logic [7:0]  r_opc, r_lo, r_prog_q, r_stk_q;
    logic [15:0] r_tgt;
    logic        r_zb, r_stk_v;
    t_res        r_res;

    // stores
    logic [7:0]  r_prog_mem [PROG_DEPTH];
    logic [7:0]  r_stk_mem  [256];
    logic [255:0] r_stk_vld;

    logic          w_at_end, w_ld_ok, w_stk_we, w_stk_re;
    logic [AW-1:0] w_ld_idx;
    logic [7:0]    w_byte, w_stk_byte, w_stk_addr, w_stk_wd;
    logic [8:0]    w_sum;
    t_status       w_status;

    // effective length is the smaller of program_length and the store depth
    assign w_at_end = (17'(r_pc) >= 17'(r_prog_len)) || (17'(r_pc) >= 17'(PROG_DEPTH));
    assign w_ld_ok  = (17'(i_in.addr) < 17'(PROG_DEPTH));
    assign w_ld_idx = AW'(i_in.addr);

    // fetched byte reads zero past the end; unwritten stack slots read zero
    assign w_byte     = r_zb ? 8'd0 : r_prog_q;
    assign w_stk_byte = r_stk_v ? r_stk_q : 8'd0;
    assign w_sum      = {1'b0, r_acc} + {1'b0, w_byte} + 9'(r_cf);

    // stack port: push writes at sp, pop reads at sp+1
    assign w_stk_we   = i_cmd.push_hi | i_cmd.push_lo_jump;
    assign w_stk_re   = i_cmd.pop_start | i_cmd.pop_lo;
    assign w_stk_addr = w_stk_we ? r_sp : r_sp + 8'd1;
    assign w_stk_wd   = i_cmd.push_hi ? r_pc[15:8] : r_pc[7:0];

    // status of the core as it stands
    always_comb begin
        priority if (r_halt != ST_RUN) w_status = r_halt;
        else if (w_at_end)             w_status = ST_ATEND;
        else if (r_steps >= r_limit)   w_status = ST_LIMIT;
        else                           w_status = ST_RUN;
    end

    assign o_stat.fetch_byte = w_byte;
    assign o_stat.opc        = r_opc;
    assign o_stat.zf         = r_zf;
    assign o_stat.run        = (w_status == ST_RUN);
    assign o_res             = r_res;
    assign o_res_valid       = r_res_valid;

    // program store, single port
    always_ff @(posedge i_clk) begin
        if (i_cmd.prog_write && w_ld_ok) begin
            r_prog_mem[w_ld_idx] <= i_in.data;
        end else if (i_cmd.fetch) begin
            r_prog_q <= r_prog_mem[r_pc[AW-1:0]];
        end
    end

    // stack store, single port
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[w_stk_addr] <= w_stk_wd;
        end
        if (w_stk_re) begin
            r_stk_q <= r_stk_mem[w_stk_addr];
            r_stk_v <= r_stk_vld[w_stk_addr];
        end
    end

    // stack slot valid bits, cleared only by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stk_vld <= '0;
        end else if (w_stk_we) begin
            r_stk_vld[w_stk_addr] <= 1'b1;
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_zb <= w_at_end;
        end
        if (i_cmd.clr_opc) begin
            r_opc <= 8'd0;
        end else if (i_cmd.take_opc) begin
            r_opc <= w_byte;
        end
        if (i_cmd.take_lo) begin
            r_lo <= w_byte;
        end else if (i_cmd.pop_lo) begin
            r_lo <= w_stk_byte;
        end
        if (i_cmd.push_hi) begin
            r_tgt <= {w_byte, r_lo};
        end
        if (i_cmd.report) begin
            r_res.status       <= w_status;
            r_res.prog_counter <= r_pc;
            r_res.opcode       <= r_opc;
            r_res.acc          <= r_acc;
            r_res.index_reg    <= r_x;
            r_res.zero_flag    <= r_zf;
            r_res.carry_flag   <= r_cf;
            r_res.stack_ptr    <= r_sp;
            r_res.step_count   <= r_steps;
        end
    end

    // architectural registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 8'd0;
            r_x         <= 8'd0;
            r_pc        <= 16'd0;
            r_sp        <= SP_RST;
            r_zf        <= 1'b0;
            r_cf        <= 1'b0;
            r_halt      <= ST_RUN;
            r_steps     <= 16'd0;
            r_prog_len  <= PROG_LEN_RST;
            r_limit     <= STEP_LIMIT_RST;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.report;

            // configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PROG_LEN:   r_prog_len <= i_cfg_data[8:0];
                    CFG_STEP_LIMIT: r_limit    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.restart) begin
                r_acc   <= 8'd0;
                r_x     <= 8'd0;
                r_pc    <= 16'd0;
                r_sp    <= SP_RST;
                r_zf    <= 1'b0;
                r_cf    <= 1'b0;
                r_halt  <= ST_RUN;
                r_steps <= 16'd0;
            end

            // byte fetch: stop at the end, otherwise advance pc
            if (i_cmd.fetch) begin
                if (w_at_end) begin
                    r_halt <= ST_PASTEND;
                end else begin
                    r_pc <= r_pc + 16'd1;
                end
            end

            if (i_cmd.step_inc) begin
                r_steps <= r_steps + 16'd1;
            end

            // immediate instructions
            if (i_cmd.imm_exec) begin
                unique case (r_opc)
                    OPC_LDA: begin
                        r_acc <= w_byte;
                        r_zf  <= (w_byte == 8'd0);
                    end
                    OPC_LDX: begin
                        r_x  <= w_byte;
                        r_zf <= (w_byte == 8'd0);
                    end
                    OPC_ADC: begin
                        r_acc <= w_sum[7:0];
                        r_cf  <= w_sum[8];
                        r_zf  <= (w_sum[7:0] == 8'd0);
                    end
                    default: ;
                endcase
            end

            if (i_cmd.inc_x) begin
                r_x  <= r_x + 8'd1;
                r_zf <= (r_x + 8'd1 == 8'd0);
            end
            if (i_cmd.dec_x) begin
                r_x  <= r_x - 8'd1;
                r_zf <= (r_x - 8'd1 == 8'd0);
            end

            if (i_cmd.set_hlt) begin
                r_halt <= ST_HLT;
            end
            if (i_cmd.set_badop) begin
                r_halt <= ST_BADOP;
            end

            // jumps, calls and returns
            if (i_cmd.load_tgt) begin
                r_pc <= {w_byte, r_lo};
            end
            if (i_cmd.push_hi) begin
                r_sp <= r_sp - 8'd1;
            end
            if (i_cmd.push_lo_jump) begin
                r_sp <= r_sp - 8'd1;
                r_pc <= r_tgt;
            end
            if (i_cmd.pop_start || i_cmd.pop_lo) begin
                r_sp <= r_sp + 8'd1;
            end
            if (i_cmd.pop_done) begin
                r_pc <= {w_stk_byte, r_lo};
            end
        end
    end

endmodule
